>>> hw/rtl/abb_pkg.sv
// Package: screen geometry, configuration codes and shared types of the pixel blitter.
package abb_pkg;

	localparam int SCREEN_WIDTH  = 128;
	localparam int SCREEN_HEIGHT = 128;
	localparam int STORE_DEPTH   = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int ADDR_W        = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	localparam int COORD_W = 10;
	localparam int CFG_W   = 11;
	localparam int CIDX_W  = 3;

	typedef enum logic [CIDX_W-1:0] {
		CFG_OFFSET_X     = 3'd0,
		CFG_OFFSET_Y     = 3'd1,
		CFG_IMAGE_WIDTH  = 3'd2,
		CFG_IMAGE_HEIGHT = 3'd3,
		CFG_ALPHA_ENABLE = 3'd4,
		CFG_MIRROR       = 3'd5
	} cfg_idx_t;

	localparam logic MODE_BLIT = 1'b0;
	localparam logic MODE_READ = 1'b1;

	// Index 0 is red, 1 green, 2 blue.
	typedef logic [2:0][7:0] rgb_t;

	typedef struct packed {
		logic signed [CFG_W-1:0] offset_x;
		logic signed [CFG_W-1:0] offset_y;
		logic [CFG_W-1:0]        image_width;
		logic [CFG_W-1:0]        image_height;
		logic                    alpha_enable;
		logic                    mirror;
	} cfg_t;

	// Store location and what to do there.
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic              done;
		logic              wr;
		logic              blend;
	} loc_t;

endpackage

>>> hw/rtl/abb_ifs.sv
// Interfaces: source pixel channel and result channel of the pixel blitter.
interface abb_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [9:0] col;
	logic [9:0] row;
	logic [7:0] src_red;
	logic [7:0] src_green;
	logic [7:0] src_blue;
	logic [7:0] src_alpha;

	modport source(output valid, mode, col, row, src_red, src_green, src_blue, src_alpha,
		input ready);
	modport sink(input valid, mode, col, row, src_red, src_green, src_blue, src_alpha,
		output ready);
endinterface

interface abb_out_if;
	logic       valid;
	logic       ready;
	logic       done_res;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source(output valid, done_res, red, green, blue, input ready);
	modport sink(input valid, done_res, red, green, blue, output ready);
endinterface

>>> hw/rtl/abb_addr.sv
// Address stage: pixel to store location; blits mirror, offset, clip, flip the row.
module abb_addr import abb_pkg::*; (
	input  cfg_t               cfg,
	input  logic               mode,
	input  logic [COORD_W-1:0] col,
	input  logic [COORD_W-1:0] row,
	input  logic [7:0]         alpha,
	output loc_t               loc
);

	localparam logic signed [12:0] SW_S = 13'(SCREEN_WIDTH);
	localparam logic signed [12:0] SH_S = 13'(SCREEN_HEIGHT);

	logic              in_image;
	logic [12:0]       xm;
	logic signed [12:0] xs;
	logic signed [12:0] ys;
	logic              on_screen;
	logic [12:0]       yf;
	logic [19:0]       lin_blit;
	logic [19:0]       lin_read;
	logic              read_ok;

	always_comb begin
		in_image = ({1'b0, col} < cfg.image_width) && ({1'b0, row} < cfg.image_height);
		xm = cfg.mirror ? (13'(cfg.image_width) - 13'(col) - 13'd1) : 13'(col);
		xs = $signed(xm) + 13'(cfg.offset_x);
		ys = $signed(13'(row)) + 13'(cfg.offset_y);
		on_screen = !xs[12] && !ys[12] && (xs < SW_S) && (ys < SH_S);
		// store is bottom-up: flip the row
		yf = 13'(SCREEN_HEIGHT - 1) - 13'(ys);
		lin_blit = 20'(yf[COORD_W-1:0]) * 20'(SCREEN_WIDTH) + 20'(xs[COORD_W-1:0]);
		lin_read = 20'(row) * 20'(SCREEN_WIDTH) + 20'(col);
		read_ok = (11'(col) < 11'(SCREEN_WIDTH)) && (11'(row) < 11'(SCREEN_HEIGHT));

		if (mode == MODE_READ) begin
			loc.addr  = ADDR_W'(lin_read);
			loc.done  = read_ok;
			loc.wr    = 1'b0;
			loc.blend = 1'b0;
		end else begin
			loc.addr  = ADDR_W'(lin_blit);
			loc.done  = in_image && on_screen && !(cfg.alpha_enable && (alpha == 8'd0));
			loc.wr    = loc.done;
			loc.blend = cfg.alpha_enable;
		end
	end

endmodule

>>> hw/rtl/abb_store.sv
// Frame store: one read and one write port, registered read, clearing sweep after reset.
module abb_store import abb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output rgb_t              rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  rgb_t              wr_data,
	output logic              clearing
);

	rgb_t              mem [STORE_DEPTH];
	logic              clearing_q;
	logic [ADDR_W-1:0] clr_cnt_q;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_wa;
	rgb_t              mem_wd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
			if (clr_cnt_q == ADDR_W'(STORE_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// sweep owns the write port until every entry is black
	always_comb begin
		mem_we = clearing_q || wr_en;
		mem_wa = clearing_q ? clr_cnt_q : wr_addr;
		mem_wd = clearing_q ? rgb_t'('0) : wr_data;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	assign clearing = clearing_q;

endmodule

>>> hw/rtl/alpha_blend_pixel_blitter.sv
// Top level: alpha-blending pixel blitter over an RGB frame store.
// Throughput: one transaction per cycle, set by the store's one read and one write port,
// while the skid is empty and no sweep runs; results pass stage 1, stage 2 and out_q.
// A two-deep output (register plus skid) keeps input flowing while one result waits.
// Reset: registers take their reset values; a clearing sweep writes black to all
// STORE_DEPTH (16384) entries, one per cycle, with pixel.ready low meanwhile.
module alpha_blend_pixel_blitter import abb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	abb_in_if.sink            pixel,
	abb_out_if.source         result
);

	typedef struct packed {
		logic done;
		rgb_t color;
	} res_t;

	// configuration
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset_x     <= '0;
			cfg_q.offset_y     <= '0;
			cfg_q.image_width  <= CFG_W'(128);
			cfg_q.image_height <= CFG_W'(128);
			cfg_q.alpha_enable <= 1'b0;
			cfg_q.mirror       <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_OFFSET_X:     cfg_q.offset_x     <= $signed(cfg_data);
				CFG_OFFSET_Y:     cfg_q.offset_y     <= $signed(cfg_data);
				CFG_IMAGE_WIDTH:  cfg_q.image_width  <= cfg_data;
				CFG_IMAGE_HEIGHT: cfg_q.image_height <= cfg_data;
				CFG_ALPHA_ENABLE: cfg_q.alpha_enable <= cfg_data[0];
				CFG_MIRROR:       cfg_q.mirror       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// handshake and pipeline advance
	logic skid_valid_q;
	logic out_valid_q;
	logic clearing;
	logic adv;
	logic acc;

	// the whole pipeline moves together; it stops only once the skid holds a result
	assign adv          = !skid_valid_q;
	assign pixel.ready  = adv && !clearing;
	assign acc          = pixel.valid && pixel.ready;

	// address stage, store read issued at acceptance
	loc_t loc;
	rgb_t rd_data;
	rgb_t src_in;

	assign src_in = {pixel.src_blue, pixel.src_green, pixel.src_red};

	abb_addr u_addr (
		.cfg   (cfg_q),
		.mode  (pixel.mode),
		.col   (pixel.col),
		.row   (pixel.row),
		.alpha (pixel.src_alpha),
		.loc   (loc)
	);

	logic valid_s1;
	loc_t loc_s1;
	rgb_t src_s1;
	logic [7:0] alpha_s1;

	logic valid_s2;
	loc_t loc_s2;
	rgb_t src_s2;
	rgb_t dst_s2;
	logic [2:0][15:0] pd_s2;
	logic [2:0][15:0] ps_s2;

	rgb_t new_s2;
	logic wr_now;

	// last write, seen by the item whose read shared its clock edge
	logic              lw_valid_q;
	logic [ADDR_W-1:0] lw_addr_q;
	rgb_t              lw_data_q;

	assign wr_now = adv && valid_s2 && loc_s2.wr;

	abb_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (acc),
		.rd_addr  (loc.addr),
		.rd_data  (rd_data),
		.wr_en    (wr_now),
		.wr_addr  (loc_s2.addr),
		.wr_data  (new_s2),
		.clearing (clearing)
	);

	// stage 1: forward pending writes onto the read data, then multiply
	rgb_t dst_s1;

	always_comb begin
		priority if (valid_s2 && loc_s2.wr && (loc_s2.addr == loc_s1.addr)) begin
			dst_s1 = new_s2;
		end else if (lw_valid_q && (lw_addr_q == loc_s1.addr)) begin
			dst_s1 = lw_data_q;
		end else begin
			dst_s1 = rd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			lw_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1   <= acc;
			valid_s2   <= valid_s1;
			lw_valid_q <= wr_now;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (acc) begin
				loc_s1   <= loc;
				src_s1   <= src_in;
				alpha_s1 <= pixel.src_alpha;
			end
			loc_s2 <= loc_s1;
			src_s2 <= src_s1;
			dst_s2 <= dst_s1;
			for (int c = 0; c < 3; c++) begin
				pd_s2[c] <= 16'(dst_s1[c]) * 16'(8'd255 - alpha_s1);
				ps_s2[c] <= 16'(src_s1[c]) * 16'(alpha_s1);
			end
			lw_addr_q <= loc_s2.addr;
			lw_data_q <= new_s2;
		end
	end

	// stage 2: sum and divide by 255 (exact for sums up to 255*255)
	logic [2:0][16:0] sum_s2;
	logic [2:0][16:0] q_s2;
	res_t res_s2;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum_s2[c] = 17'(pd_s2[c]) + 17'(ps_s2[c]);
			q_s2[c]   = sum_s2[c] + 17'd1 + (sum_s2[c] >> 8);
			if (loc_s2.blend) begin
				new_s2[c] = q_s2[c][15:8];
			end else if (loc_s2.wr) begin
				new_s2[c] = src_s2[c];
			end else begin
				new_s2[c] = dst_s2[c];
			end
		end
		res_s2.done  = loc_s2.done;
		res_s2.color = loc_s2.done ? new_s2 : rgb_t'('0);
	end

	// output register plus skid
	logic r_valid;
	logic pop;
	res_t out_q;
	res_t skid_q;

	assign r_valid = adv && valid_s2;
	assign pop     = out_valid_q && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= r_valid;
			end
		end else if (r_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (r_valid) begin
				out_q <= res_s2;
			end
		end else if (r_valid) begin
			skid_q <= res_s2;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.done_res = out_q.done;
	assign result.red      = out_q.color[0];
	assign result.green    = out_q.color[1];
	assign result.blue     = out_q.color[2];

endmodule
